// ===== hw/rtl/sida_pkg.sv =====
// Package: shared types and character codes for the signed decimal text unit.
package sida_pkg;

  localparam logic [6:0] CODE_MINUS = 7'd45;
  localparam logic [6:0] CODE_ZERO  = 7'd48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic shift;
  } bcd_ctrl_t;

endpackage

// ===== hw/rtl/sida_in_if.sv =====
// Interface: input channel carrying one signed integer per transaction.
interface sida_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== hw/rtl/sida_out_if.sv =====
// Interface: output channel carrying one ASCII character per transaction.
interface sida_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== hw/rtl/sida_bcd.sv =====
// Bit-serial double-dabble register: binary magnitude in, BCD digits out MSB first.
module sida_bcd #(
  parameter int VALUE_WIDTH = 32,
  parameter int NUM_DIGITS  = 10
) (
  input  logic                   clk,
  input  sida_pkg::bcd_ctrl_t    ctrl,
  input  logic [VALUE_WIDTH-1:0] load_mag,
  output logic [3:0]             top_digit
);
  import sida_pkg::*;

  localparam int BCD_W = 4 * NUM_DIGITS;

  logic [VALUE_WIDTH-1:0] mag;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;

  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag <= load_mag;
      bcd <= '0;
    end else if (ctrl.conv) begin
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], mag[VALUE_WIDTH-1]};
    end else if (ctrl.shift) begin
      bcd <= {bcd[BCD_W-5:0], 4'd0};
    end
  end

  assign top_digit = bcd[BCD_W-1 -: 4];

endmodule

// ===== hw/rtl/signed_int_to_decimal_ascii_unit.sv =====
// Top level: converts a signed integer to its decimal ASCII text, one character per transaction.
//
// Each accepted integer yields its decimal text, most significant character first, with a
// leading '-' for negative values, no leading zeros ('0' for zero), and last_char set on the
// final character. A new integer is accepted only when the previous one has been fully
// emitted. An item is accepted in ST_IDLE, then shifted through the bit-serial
// double-dabble register in ST_CONV; ST_SKIP then drops the leading zero digits of the
// NUM_DIGITS-digit BCD result and finds the first digit, ST_SIGN sends a minus sign for a
// negative value, and ST_EMIT sends the digits. The output side can stall ST_SIGN and
// ST_EMIT. The last character may still sit in the output register while the next integer
// is taken.
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  sida_in_if.sink   number,
  sida_out_if.source text
);
  import sida_pkg::*;

  localparam int NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [REM_W-1:0] rem, rem_next;
  logic             neg, neg_next;
  bcd_ctrl_t        ctrl;
  logic [3:0]       top_digit;
  logic [VALUE_WIDTH-1:0] load_mag;
  logic             out_free;
  logic             out_load;
  logic [6:0]       out_char;
  logic             out_last;

  assign load_mag = number.value[VALUE_WIDTH-1] ? (~number.value + 1'b1) : number.value;
  assign out_free = !text.valid || text.ready;
  assign number.ready = (state == ST_IDLE);

  sida_bcd #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_bcd (
    .clk       (clk),
    .ctrl      (ctrl),
    .load_mag  (load_mag),
    .top_digit (top_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      rem   <= '0;
      neg   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      rem   <= rem_next;
      neg   <= neg_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    rem_next   = rem;
    neg_next   = neg;
    ctrl       = '0;
    out_load   = 1'b0;
    out_char   = CODE_ZERO + {3'd0, top_digit};
    out_last   = (rem == REM_W'(1));
    case (state)
      ST_IDLE: begin
        if (number.valid) begin
          ctrl.load  = 1'b1;
          neg_next   = number.value[VALUE_WIDTH-1];
          cnt_next   = CNT_W'(VALUE_WIDTH);
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.conv = 1'b1;
        cnt_next  = cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          rem_next   = REM_W'(NUM_DIGITS);
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && rem != REM_W'(1)) begin
          ctrl.shift = 1'b1;
          rem_next   = rem - 1'b1;
        end else begin
          state_next = neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        out_char = CODE_MINUS;
        out_last = 1'b0;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          ctrl.shift = 1'b1;
          rem_next   = rem - 1'b1;
          if (rem == REM_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text.valid <= 1'b0;
    end else if (out_load) begin
      text.valid <= 1'b1;
    end else if (text.ready) begin
      text.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      text.char_code <= out_char;
      text.last_char <= out_last;
    end
  end

  // accepted integer always enters conversion
  a_accept_conv: assert property (@(posedge clk) disable iff (rst)
    (number.valid && number.ready) |=> (state == ST_CONV))
    else $error("accepted integer did not start conversion");

  // digit register holds a decimal digit once conversion is done
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP || state == ST_EMIT) |-> (top_digit <= 4'd9))
    else $error("BCD digit out of range");

  // digit count never runs out while characters remain
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP || state == ST_SIGN || state == ST_EMIT) |-> (rem != '0))
    else $error("digit count exhausted");

  // minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_char == CODE_MINUS) |-> !out_last)
    else $error("minus sign flagged as last character");

  // final character returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_last) |=> (state == ST_IDLE))
    else $error("block not idle after final character");

endmodule

// ===== test/tb_signed_int_to_decimal_ascii_unit.sv =====
// Testbench: signed integer to decimal ASCII unit, predicted text checked per character.
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii_unit;
  import sida_pkg::*;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = VALUE_WIDTH / 3 + 2;
  localparam int STALL_LIMIT = 1500;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } text_char_t;

  logic clk;
  logic rst;

  sida_in_if #(.VALUE_WIDTH(VALUE_WIDTH)) number_if ();
  sida_out_if text_if ();

  signed_int_to_decimal_ascii_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .number (number_if),
    .text   (text_if)
  );

  text_char_t expected_text[$];
  int         mismatch_count    = 0;
  int         idle_cycles       = 0;
  int         text_hold_cycles  = 0;
  bit         number_gaps_on    = 1'b1;
  bit         text_stalls_on    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Decimal text of one value, pushed onto the expected character queue.
  function automatic void predict_text(input logic [VALUE_WIDTH-1:0] raw);
    logic [VALUE_WIDTH-1:0] mag;
    logic [3:0]             dig[MAX_DIGITS];
    int                     n;
    int                     i;
    text_char_t             c;
    mag = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
    n = 0;
    do begin
      dig[n] = 4'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0);
    if (raw[VALUE_WIDTH-1]) begin
      c.char_code = CODE_MINUS;
      c.last_char = 1'b0;
      expected_text.push_back(c);
    end
    for (i = n - 1; i >= 0; i--) begin
      c.char_code = CODE_ZERO + 7'(dig[i]);
      c.last_char = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] pick_number();
    logic [VALUE_WIDTH-1:0] v;
    logic [VALUE_WIDTH-1:0] p;
    int                     k;
    p = 1;
    case ($urandom_range(0, 3))
      0: v = $urandom();
      1: begin
        k = $urandom_range(1, 9);
        repeat (k) p = p * 10;
        v = $urandom_range(0, p - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
      2: begin
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        v = p + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
          1: v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
          2: v = $urandom_range(0, 15);
          default: v = -$urandom_range(1, 15);
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_number(input logic [VALUE_WIDTH-1:0] v);
    int gap;
    gap = (number_gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      number_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    number_if.valid = 1'b1;
    number_if.value = v;
    do @(posedge clk); while (!number_if.ready);
    predict_text(v);
  endtask

  task automatic drain_text();
    @(negedge clk);
    number_if.valid = 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_number(0);
    send_number(1);
    send_number(-1);
    send_number(9);
    send_number(-9);
    send_number(10);
    send_number(-10);
    send_number(99);
    send_number(100);
    send_number(1000000000);
    send_number(-999999999);
    send_number(123456789);
    send_number(-123456789);
    send_number(32'h7fffffff);
    send_number(32'h80000000);
    send_number(32'h80000001);
    send_number(32'haaaaaaaa);
    send_number(32'h55555555);
    drain_text();
  endtask

  // Output held off while numbers keep coming; input must stall.
  task automatic test_backpressure();
    text_hold_cycles = HOLD_CYCLES;
    send_number(32'h80000000);
    send_number(-1999999999);
    send_number(pick_number());
    send_number(pick_number());
    send_number(7);
    drain_text();
  endtask

  task automatic test_random(input int count);
    repeat (count) send_number(pick_number());
    drain_text();
  endtask

  initial begin : text_ready_drive
    int stall_len;
    text_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (text_hold_cycles > 0) begin
        text_if.ready = 1'b0;
        text_hold_cycles--;
      end else if (text_stalls_on && $urandom_range(0, 7) == 0) begin
        stall_len = $urandom_range(1, 14);
        text_if.ready = 1'b0;
        repeat (stall_len - 1) @(negedge clk);
      end else begin
        text_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_text
    text_char_t want;
    if (!rst && text_if.valid && text_if.ready) begin
      if (expected_text.size() == 0) begin
        $error("unexpected character: char_code %0d last_char %0b",
               text_if.char_code, text_if.last_char);
        mismatch_count++;
      end else begin
        want = expected_text.pop_front();
        if (text_if.char_code !== want.char_code) begin
          $error("char_code: expected %0d, actual %0d", want.char_code, text_if.char_code);
          mismatch_count++;
        end
        if (text_if.last_char !== want.last_char) begin
          $error("last_char: expected %0b, actual %0b", want.last_char, text_if.last_char);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (number_if.valid && number_if.ready) || (text_if.valid && text_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    number_if.valid = 1'b0;
    number_if.value = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backpressure();
    test_random(250);
    number_gaps_on = 1'b0;
    text_stalls_on = 1'b0;
    test_random(50);

    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && expected_text.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== signed_int_to_decimal_ascii_unit.f =====
hw/rtl/sida_pkg.sv
hw/rtl/sida_in_if.sv
hw/rtl/sida_out_if.sv
hw/rtl/sida_bcd.sv
hw/rtl/signed_int_to_decimal_ascii_unit.sv
test/tb_signed_int_to_decimal_ascii_unit.sv
